[src/tcpc_pkg.sv]
// Shared types and constants for the track confirm people counter.
package tcpc_pkg;

    localparam int unsigned OP_W      = 3;
    localparam int unsigned IN_ID_W   = 12;
    localparam int unsigned OUT_CNT_W = 24;
    localparam int unsigned THRESH_W  = 4;
    localparam int unsigned SIGHT_W   = 4;
    localparam int unsigned ENTRY_W   = SIGHT_W + 1;

    localparam logic [OP_W-1:0] OP_ENTER     = 3'd0;
    localparam logic [OP_W-1:0] OP_PASS      = 3'd1;
    localparam logic [OP_W-1:0] OP_NEW_WIN   = 3'd2;
    localparam logic [OP_W-1:0] OP_END_WIN   = 3'd3;
    localparam logic [OP_W-1:0] OP_RESET_ALL = 3'd4;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 4'd3;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [IN_ID_W-1:0] track_id;
    } t_in;

    typedef struct packed {
        logic                 counted;
        logic                 window_open;
        logic                 closed_window;
        logic [OUT_CNT_W-1:0] enter_total;
        logic [OUT_CNT_W-1:0] pass_total;
        logic [OUT_CNT_W-1:0] people_total;
    } t_out;

    // one executed item, handed from track control to the window counters
    typedef struct packed {
        logic            fire;
        logic [OP_W-1:0] op;
        logic            counted;
    } t_evt;

endpackage

[src/tcpc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module tcpc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/tcpc_track_ctl.sv]
// Item sequencer: track table read-modify-write, clearing pass and threshold register.
module tcpc_track_ctl #(
    parameter int unsigned TRACK_ID_BITS = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  tcpc_pkg::t_in                      i_in,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tcpc_pkg::THRESH_W-1:0]      i_cfg_data,
    input  logic                               i_open,
    input  logic                               i_out_free,
    output tcpc_pkg::t_evt                     o_evt,
    output logic                               o_ram_we,
    output logic [TRACK_ID_BITS-1:0]           o_ram_waddr,
    output logic [tcpc_pkg::ENTRY_W-1:0]       o_ram_wdata,
    output logic [TRACK_ID_BITS-1:0]           o_ram_raddr,
    input  logic [tcpc_pkg::ENTRY_W-1:0]       i_ram_rdata
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0]                         r_state, n_state;
    logic [TRACK_ID_BITS-1:0]           r_clr, n_clr;
    logic [TRACK_ID_BITS-1:0]           r_id;
    logic [tcpc_pkg::OP_W-1:0]          r_op;
    logic [tcpc_pkg::THRESH_W-1:0]      r_thresh;

    logic                               w_accept;
    logic [TRACK_ID_BITS-1:0]           w_in_id;
    logic                               w_sight;
    logic                               w_mark;
    logic [tcpc_pkg::SIGHT_W-1:0]       w_cnt;
    logic                               w_act;
    logic                               w_fire;
    logic                               w_below;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_accept    = i_in_valid && (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_id     = TRACK_ID_BITS'(i_in.track_id);

    assign w_sight = (r_op == tcpc_pkg::OP_ENTER) || (r_op == tcpc_pkg::OP_PASS);
    assign w_mark  = i_ram_rdata[tcpc_pkg::SIGHT_W];
    assign w_cnt   = i_ram_rdata[tcpc_pkg::SIGHT_W-1:0];
    assign w_act   = w_sight && i_open && !w_mark;
    assign w_below = (w_cnt < r_thresh);
    assign w_fire  = (r_state == ST_EXEC) && i_out_free;

    assign o_ram_raddr = w_accept ? w_in_id : r_id;

    always_comb begin
        o_ram_we    = 1'b0;
        o_ram_waddr = r_id;
        o_ram_wdata = '0;
        if (r_state == ST_CLEAR) begin
            o_ram_we    = 1'b1;
            o_ram_waddr = r_clr;
        end else if (w_fire && w_act) begin
            o_ram_we = 1'b1;
            if (w_below) begin
                o_ram_wdata = {1'b0, tcpc_pkg::SIGHT_W'(w_cnt + 1'b1)};
            end else begin
                o_ram_wdata = {1'b1, {tcpc_pkg::SIGHT_W{1'b0}}};
            end
        end
    end

    always_comb begin
        o_evt.fire    = w_fire;
        o_evt.op      = r_op;
        o_evt.counted = w_act && !w_below;
    end

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        case (r_state)
            ST_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (w_fire) begin
                    if (r_op == tcpc_pkg::OP_RESET_ALL) begin
                        n_state = ST_CLEAR;
                        n_clr   = '0;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_thresh <= tcpc_pkg::THRESH_RESET;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            if (i_cfg_valid && o_cfg_ready) begin
                r_thresh <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op <= i_in.op;
            r_id <= w_in_id;
        end
    end

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_EXEC))
        else $error("accepted beat did not enter execution");

    a_exec_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_EXEC) && !i_out_free) |=> ((r_state == ST_EXEC) && $stable(r_id)))
        else $error("execution left while result slot busy");

    a_exec_write_sight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_EXEC) && o_ram_we) |-> (w_sight && i_open && w_fire))
        else $error("track table written by a non-sighting beat");

endmodule

[src/tcpc_window.sv]
// Window state, saturating counts and the result register.
module tcpc_window #(
    parameter int unsigned COUNT_BITS = 24
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tcpc_pkg::t_evt i_evt,
    output logic           o_open,
    output logic           o_out_free,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output tcpc_pkg::t_out o_out
);

    logic                  r_open, n_open;
    logic [COUNT_BITS-1:0] r_enter, n_enter;
    logic [COUNT_BITS-1:0] r_pass, n_pass;
    logic [COUNT_BITS-1:0] r_people, n_people;
    logic                  r_out_valid;
    tcpc_pkg::t_out        r_out, n_out;
    logic [COUNT_BITS-1:0] w_rep_enter, w_rep_pass, w_rep_people;
    logic                  w_closed;

    assign o_open      = r_open;
    assign o_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_open       = r_open;
        n_enter      = r_enter;
        n_pass       = r_pass;
        n_people     = r_people;
        w_closed     = 1'b0;
        w_rep_enter  = r_enter;
        w_rep_pass   = r_pass;
        w_rep_people = r_people;
        case (i_evt.op)
            tcpc_pkg::OP_ENTER, tcpc_pkg::OP_PASS: begin
                if (i_evt.counted) begin
                    if (i_evt.op == tcpc_pkg::OP_ENTER) begin
                        n_enter = (r_enter == '1) ? r_enter : r_enter + 1'b1;
                    end else begin
                        n_pass = (r_pass == '1) ? r_pass : r_pass + 1'b1;
                    end
                    n_people = (r_people == '1) ? r_people : r_people + 1'b1;
                end
                w_rep_enter  = n_enter;
                w_rep_pass   = n_pass;
                w_rep_people = n_people;
            end
            tcpc_pkg::OP_NEW_WIN, tcpc_pkg::OP_END_WIN: begin
                w_closed = r_open;
                if (!r_open) begin
                    w_rep_enter  = '0;
                    w_rep_pass   = '0;
                    w_rep_people = '0;
                end
                n_enter  = '0;
                n_pass   = '0;
                n_people = '0;
                n_open   = (i_evt.op == tcpc_pkg::OP_NEW_WIN);
            end
            tcpc_pkg::OP_RESET_ALL: begin
                n_enter      = '0;
                n_pass       = '0;
                n_people     = '0;
                n_open       = 1'b0;
                w_rep_enter  = '0;
                w_rep_pass   = '0;
                w_rep_people = '0;
            end
            default: begin
            end
        endcase
        n_out.counted       = i_evt.counted;
        n_out.window_open   = n_open;
        n_out.closed_window = w_closed;
        n_out.enter_total   = tcpc_pkg::OUT_CNT_W'(w_rep_enter);
        n_out.pass_total    = tcpc_pkg::OUT_CNT_W'(w_rep_pass);
        n_out.people_total  = tcpc_pkg::OUT_CNT_W'(w_rep_people);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open      <= 1'b0;
            r_enter     <= '0;
            r_pass      <= '0;
            r_people    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_evt.fire) begin
                r_open      <= n_open;
                r_enter     <= n_enter;
                r_pass      <= n_pass;
                r_people    <= n_people;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_evt.fire) begin
            r_out <= n_out;
        end
    end

    a_fire_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_evt.fire |-> (!r_out_valid || !i_out_stall))
        else $error("result overwritten before it was taken");

    a_counted_needs_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_evt.fire && i_evt.counted) |-> r_open)
        else $error("person counted with no window open");

    a_closed_counts_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_open |-> ((r_enter == '0) && (r_pass == '0) && (r_people == '0)))
        else $error("counts held while no window open");

endmodule

[src/track_confirm_people_counter_unit.sv]
// An accepted beat waits in the execute state until the result register can take it.
// The input stalls until the current beat has executed its track RAM read-modify-write.
// A full result register stalls execution and so the input.
// Reset (synchronous, active low) and the reset-all op run a clearing pass over all
// 2**TRACK_ID_BITS entries (4096 by default) of the track RAM with the input stalled.
module track_confirm_people_counter_unit #(
    parameter int unsigned TRACK_ID_BITS = 12,
    parameter int unsigned COUNT_BITS    = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  tcpc_pkg::t_in                 i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output tcpc_pkg::t_out                o_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tcpc_pkg::THRESH_W-1:0] i_cfg_data
);

    localparam int unsigned TrackDepth = 1 << TRACK_ID_BITS;

    tcpc_pkg::t_evt                 w_evt;
    logic                           w_open;
    logic                           w_out_free;
    logic                           w_ram_we;
    logic [TRACK_ID_BITS-1:0]       w_ram_waddr;
    logic [TRACK_ID_BITS-1:0]       w_ram_raddr;
    logic [tcpc_pkg::ENTRY_W-1:0]   w_ram_wdata;
    logic [tcpc_pkg::ENTRY_W-1:0]   w_ram_rdata;

    tcpc_track_ctl #(
        .TRACK_ID_BITS(TRACK_ID_BITS)
    ) u_ctl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_open     (w_open),
        .i_out_free (w_out_free),
        .o_evt      (w_evt),
        .o_ram_we   (w_ram_we),
        .o_ram_waddr(w_ram_waddr),
        .o_ram_wdata(w_ram_wdata),
        .o_ram_raddr(w_ram_raddr),
        .i_ram_rdata(w_ram_rdata)
    );

    tcpc_ram #(
        .WIDTH(tcpc_pkg::ENTRY_W),
        .DEPTH(TrackDepth)
    ) u_track_ram (
        .i_clk  (i_clk),
        .i_we   (w_ram_we),
        .i_waddr(w_ram_waddr),
        .i_wdata(w_ram_wdata),
        .i_raddr(w_ram_raddr),
        .o_rdata(w_ram_rdata)
    );

    tcpc_window #(
        .COUNT_BITS(COUNT_BITS)
    ) u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_evt      (w_evt),
        .o_open     (w_open),
        .o_out_free (w_out_free),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out)
    );

endmodule
